@@ rtl/fbfl_pkg.sv @@
// Shared types and constants for the fixed-block free-list allocator.
// Depends on nothing; fbfl_ctrl, fbfl_dp and the top level import it.
package fbfl_pkg;

    localparam int POOL_BLOCKS = 1024;
    localparam int IDX_W = $clog2(POOL_BLOCKS);
    localparam int LINK_W = IDX_W + 1;
    localparam int OP_W = 1;
    localparam int COUNT_W = 16;
    localparam int HANDLE_W = 10;
    localparam int BLOCK_W = 10;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
    localparam logic [OP_W-1:0] OP_FREE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_REJECT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic init_wr;
        logic accept;
        logic exec;
    } fbfl_cmd_t;

    typedef struct packed {
        logic init_last;
    } fbfl_stat_t;

endpackage

@@ rtl/fbfl_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module fbfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/fbfl_ctrl.sv @@
// Controller state machine: initialization sweep, request accept and execute.
// Depends on fbfl_pkg.
module fbfl_ctrl
    import fbfl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  fbfl_stat_t stat,
    output fbfl_cmd_t  cmd,
    output logic       busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        busy = 1'b1;
        case (state_reg)
            ST_INIT:
            begin
                cmd.init_wr = 1'b1;
                if (stat.init_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

endmodule

@@ rtl/fbfl_dp.sv @@
// Datapath: list head, link RAM, initialization counter and result registers.
// Depends on fbfl_pkg and fbfl_ram.
module fbfl_dp
    import fbfl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  fbfl_cmd_t           cmd,
    output fbfl_stat_t          stat,
    input  logic [OP_W-1:0]     op,
    input  logic [COUNT_W-1:0]  count,
    input  logic [HANDLE_W-1:0] handle,
    output logic                done,
    output logic [BLOCK_W-1:0]  block,
    output logic [STATUS_W-1:0] status
);

    logic [IDX_W-1:0]    init_cnt_reg;
    logic [LINK_W-1:0]   head_reg;
    logic [LINK_W-1:0]   head_next;
    logic [OP_W-1:0]     op_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic                done_reg;
    logic [BLOCK_W-1:0]  block_reg;
    logic [BLOCK_W-1:0]  block_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [LINK_W-1:0]   ram_wdata;
    logic [LINK_W-1:0]   ram_rdata;
    logic                free_wr;

    fbfl_ram #(
        .WIDTH(LINK_W),
        .DEPTH(POOL_BLOCKS)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (head_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign stat.init_last = (32'(init_cnt_reg) == POOL_BLOCKS - 1);

    always_comb
    begin
        head_next = head_reg;
        block_next = '0;
        status_next = STATUS_DONE;
        free_wr = 1'b0;
        if (count_reg != COUNT_W'(1))
        begin
            status_next = STATUS_REJECT;
        end
        else if (op_reg == OP_ALLOC)
        begin
            if (32'(head_reg) >= POOL_BLOCKS)
            begin
                status_next = STATUS_EMPTY;
            end
            else
            begin
                block_next = BLOCK_W'(head_reg);
                head_next = ram_rdata;
            end
        end
        else
        begin
            if (32'(handle_reg) >= POOL_BLOCKS)
            begin
                status_next = STATUS_REJECT;
            end
            else
            begin
                free_wr = 1'b1;
                head_next = LINK_W'(handle_reg);
            end
        end
    end

    always_comb
    begin
        if (cmd.init_wr)
        begin
            ram_we = 1'b1;
            ram_waddr = init_cnt_reg;
            ram_wdata = LINK_W'(init_cnt_reg) + LINK_W'(1);
        end
        else
        begin
            ram_we = cmd.exec & free_wr;
            ram_waddr = IDX_W'(handle_reg);
            ram_wdata = head_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_cnt_reg <= '0;
            head_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (cmd.init_wr)
            begin
                init_cnt_reg <= init_cnt_reg + IDX_W'(1);
            end
            if (cmd.exec)
            begin
                head_reg <= head_next;
            end
            done_reg <= cmd.exec;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg <= op;
            count_reg <= count;
            handle_reg <= handle;
        end
        if (cmd.exec)
        begin
            block_reg <= block_next;
            status_reg <= status_next;
        end
    end

    assign done = done_reg;
    assign block = block_reg;
    assign status = status_reg;

endmodule

@@ rtl/fixed_block_free_list_allocator.sv @@
// Top level of the fixed-block free-list allocator.
// Depends on fbfl_pkg, fbfl_ctrl and fbfl_dp (which holds fbfl_ram).
//
// A request word (op, count, handle) is taken at a rising edge where start
// is high and busy is low. Each request gives exactly one result word on
// block and status, shown for one cycle while done is high.
// An allocate pops the head of the free list and returns its handle; a
// free pushes the given handle. A count other than one is rejected with
// status 1, and an allocate on an empty list gives status 2.
// The request is taken, the head's link is read from the link RAM in the
// next cycle, and the result appears in the cycle after that, together
// with busy low, so a new request may be given then. No new request is
// taken while one executes; busy stays high until its result appears.
// After reset the block sweeps the link RAM, one entry per cycle, to link
// every block to the next in ascending order, with busy held high. The
// receiver cannot stall, so results are never held.
module fixed_block_free_list_allocator
    import fbfl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [OP_W-1:0]     op,
    input  logic [COUNT_W-1:0]  count,
    input  logic [HANDLE_W-1:0] handle,
    output logic                done,
    output logic [BLOCK_W-1:0]  block,
    output logic [STATUS_W-1:0] status
);

    fbfl_cmd_t  cmd;
    fbfl_stat_t stat;

    fbfl_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    fbfl_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .stat   (stat),
        .op     (op),
        .count  (count),
        .handle (handle),
        .done   (done),
        .block  (block),
        .status (status)
    );

endmodule
